// ----- rtl/core/apc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playback clock package
// Shared types, register indexes, command codes and widths of the clip
// playback clock.
// ----------------------------------------------------------------------------
package apc_pkg;

   // Field widths.
   localparam int TIME_W   = 32;
   localparam int SECS_W   = 24;
   localparam int RATE_W   = 24;
   localparam int SPEED_W  = 17;
   localparam int PERIOD_W = 24;
   localparam int ACC_W    = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Product and delta widths.
   localparam int MUL_W   = 48;
   localparam int PROD_W  = 41;
   localparam int DELTA_W = 46;
   localparam int SUM_W   = 47;
   localparam int SET_W   = 40;

   // Remainder unit: two dividend bits retire per cycle.
   localparam int DIV_W           = 48;
   localparam int DIV_CNT_W       = 5;
   localparam int DIV_FULL_STEPS  = DIV_W / 2;
   localparam int ACC_DIV_W       = 26;
   localparam int DIV_SHORT_STEPS = ACC_DIV_W / 2;
   localparam int DIV_SHORT_SHIFT = DIV_W - ACC_DIV_W;

   // Constants of the behaviour.
   localparam logic [RATE_W-1:0]  DEFAULT_RATE  = 24'd6400;   // 25.0 in Q16.8
   localparam logic [ACC_W-1:0]   ACC_MAX       = 25'h1FFFFFF;
   localparam logic [SPEED_W-1:0] SPEED_RESET   = 17'd4096;   // 1.0 in Q4.12

   // Command codes carried by an input item.
   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_PLAY     = 3'd1,
      OP_PAUSE    = 3'd2,
      OP_STOP     = 3'd3,
      OP_SET_TIME = 3'd4
   } apc_op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED  = 3'd0,
      CSR_LOOPING  = 3'd1,
      CSR_SPEED    = 3'd2,
      CSR_RATE     = 3'd3,
      CSR_DURATION = 3'd4,
      CSR_PERIOD   = 3'd5
   } apc_csr_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [SECS_W-1:0] seconds;
   } apc_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] clip_ticks;
      logic              playing;
      logic              pose_update;
   } apc_rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic mul_p;
      logic mul_hi;
      logic mul_lo;
      logic adv;
      logic set_place;
      logic take_time;
      logic pose;
      logic take_acc;
      logic commit;
   } apc_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic op_tick;
      logic op_set;
      logic adv_ok;
      logic looping;
      logic set_div;
      logic need_acc_div;
      logic div_done;
   } apc_status_type;

endpackage

// ----- rtl/core/apc_rem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Iterative restoring remainder, two dividend bits per cycle, with a full
// 48-bit mode and a short 26-bit mode for the rate accumulator.
// ----------------------------------------------------------------------------
module apc_rem import apc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              short_mode,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [TIME_W-1:0] remainder
);

   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [TIME_W-1:0]    div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TIME_W-1:0]    rem_mid;

   // One restoring step: shift a bit in, subtract the divisor if it fits.
   function automatic logic [TIME_W-1:0] rem_step(input logic [TIME_W-1:0] r,
                                                  input logic              b,
                                                  input logic [TIME_W-1:0] d);
      logic [TIME_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[TIME_W-1:0];
   endfunction

   // Next state of the iteration.
   always_comb begin
      rem_mid = rem_step(rem_ff, quo_ff[DIV_W-1], div_ff);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = short_mode ? (dividend << DIV_SHORT_SHIFT) : dividend;
         div_in  = divisor;
         cnt_in  = short_mode ? DIV_CNT_W'(DIV_SHORT_STEPS - 1)
                              : DIV_CNT_W'(DIV_FULL_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_step(rem_mid, quo_ff[DIV_W-2], div_ff);
         quo_in = {quo_ff[DIV_W-3:0], 2'b00};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/apc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playback clock datapath
// Configuration registers, clip state, the shared multiplier, the advance
// and clamp logic, the pose rate limiter and the result register.
// ----------------------------------------------------------------------------
module apc_datapath import apc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  apc_req_type           req_payload,
   output apc_rsp_type           rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  apc_cmd_type           cmd,
   output apc_status_type        st
);

   // Configuration.
   logic                       enabled_ff, looping_ff;
   logic signed [SPEED_W-1:0]  speed_ff;
   logic [RATE_W-1:0]          rate_ff;
   logic [TIME_W-1:0]          dur_ff;
   logic [PERIOD_W-1:0]        period_ff;

   // Clip state.
   logic [TIME_W-1:0] clip_ff, clip_in;
   logic              run_ff, run_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   // Item and working registers.
   logic [2:0]         op_ff;
   logic [SECS_W-1:0]  secs_ff;
   logic [MUL_W-1:0]   p_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [DELTA_W-1:0] d_ff;
   logic [TIME_W-1:0]  nt_ff, nt_in;
   logic               nr_ff, nr_in;
   logic               ns_ff, ns_in;
   logic [ACC_W-1:0]   na_ff, na_in;
   logic               fix_ff, fix_in;
   apc_rsp_type        rsp_ff;

   logic [RATE_W-1:0]  rate_eff;
   logic               neg;
   logic [SPEED_W-1:0] mag;
   logic [SECS_W-1:0]  mul_a, mul_b;
   logic [MUL_W-1:0]   mul_y;
   logic [SUM_W-1:0]   sum_cd;
   logic               d_le_c;
   logic [DELTA_W-1:0] diff_cd;
   logic [SET_W-1:0]   set_t;
   logic [ACC_DIV_W-1:0] acc_sum;
   logic [ACC_W-1:0]   acc_sat;
   logic               changed_run, pose_skip, acc_below;
   logic               div_start, div_short, div_done;
   logic [DIV_W-1:0]   div_dividend;
   logic [TIME_W-1:0]  div_divisor, div_rem;

   // Effective rate and speed magnitude.
   assign rate_eff = (rate_ff == '0) ? DEFAULT_RATE : rate_ff;
   assign neg      = speed_ff[SPEED_W-1];
   assign mag      = neg ? (~speed_ff + SPEED_W'(1)) : speed_ff;

   // The shared multiplier serves the rate product and both speed products.
   always_comb begin
      mul_a = secs_ff;
      mul_b = rate_eff;
      if (cmd.mul_hi) begin
         mul_a = p_ff[MUL_W-1:SECS_W];
         mul_b = {{(SECS_W-SPEED_W){1'b0}}, mag};
      end else if (cmd.mul_lo) begin
         mul_a = p_ff[SECS_W-1:0];
         mul_b = {{(SECS_W-SPEED_W){1'b0}}, mag};
      end
   end
   assign mul_y = {{SECS_W{1'b0}}, mul_a} * {{SECS_W{1'b0}}, mul_b};

   // Advance arithmetic on the delta.
   assign sum_cd  = {{(SUM_W-TIME_W){1'b0}}, clip_ff} + {1'b0, d_ff};
   assign d_le_c  = d_ff <= {{(DELTA_W-TIME_W){1'b0}}, clip_ff};
   assign diff_cd = d_le_c ? ({{(DELTA_W-TIME_W){1'b0}}, clip_ff} - d_ff)
                           : (d_ff - {{(DELTA_W-TIME_W){1'b0}}, clip_ff});
   assign set_t   = p_ff[MUL_W-1:MUL_W-SET_W];

   // Pose rate limiter.
   assign acc_sum     = {1'b0, acc_ff} + {{(ACC_DIV_W-SECS_W){1'b0}}, secs_ff};
   assign acc_sat     = acc_sum[ACC_DIV_W-1] ? ACC_MAX : acc_sum[ACC_W-1:0];
   assign acc_below   = acc_sat < {{(ACC_W-PERIOD_W){1'b0}}, period_ff};
   assign changed_run = nr_ff != run_ff;
   assign pose_skip   = (nt_ff == clip_ff) && !changed_run;

   // Status towards the controller.
   always_comb begin
      st.op_tick      = op_ff == OP_TICK;
      st.op_set       = op_ff == OP_SET_TIME;
      st.adv_ok       = enabled_ff && run_ff && (dur_ff != '0) && (speed_ff != '0);
      st.looping      = looping_ff;
      st.set_div      = looping_ff && (dur_ff != '0);
      st.need_acc_div = !pose_skip && (period_ff != '0) && !acc_below;
      st.div_done     = div_done;
   end

   // Remainder unit operands.
   always_comb begin
      div_start    = (cmd.adv && looping_ff) || (cmd.set_place && st.set_div)
                     || (cmd.pose && st.need_acc_div);
      div_short    = cmd.pose;
      div_divisor  = cmd.pose ? {{(TIME_W-PERIOD_W){1'b0}}, period_ff} : dur_ff;
      div_dividend = {{(DIV_W-SET_W){1'b0}}, set_t};
      if (cmd.pose) begin
         div_dividend = {{(DIV_W-ACC_W){1'b0}}, acc_sat};
      end else if (cmd.adv) begin
         div_dividend = neg ? {{(DIV_W-DELTA_W){1'b0}}, diff_cd}
                            : {{(DIV_W-SUM_W){1'b0}}, sum_cd};
      end
   end

   apc_rem u_rem (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .short_mode (div_short),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .done       (div_done),
      .remainder  (div_rem)
   );

   // New time, run flag, strobe and accumulator of the item at work.
   always_comb begin
      nt_in  = nt_ff;
      nr_in  = nr_ff;
      ns_in  = ns_ff;
      na_in  = na_ff;
      fix_in = fix_ff;
      if (cmd.mul_p) begin
         nt_in = clip_ff;
         nr_in = run_ff;
         na_in = acc_ff;
         ns_in = 1'b0;
         case (op_ff)
            OP_PLAY: begin
               nr_in = 1'b1;
               na_in = '0;
            end
            OP_PAUSE: begin
               nr_in = 1'b0;
               na_in = '0;
            end
            OP_STOP: begin
               nt_in = '0;
               nr_in = 1'b0;
               na_in = '0;
               ns_in = 1'b1;
            end
            OP_SET_TIME: begin
               na_in = '0;
               ns_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (cmd.adv) begin
         fix_in = neg && !d_le_c;
         if (!looping_ff) begin
            if (!neg) begin
               if (sum_cd >= {{(SUM_W-TIME_W){1'b0}}, dur_ff}) begin
                  nt_in = dur_ff;
                  nr_in = 1'b0;
               end else begin
                  nt_in = sum_cd[TIME_W-1:0];
               end
            end else if (!d_le_c || (d_ff == {{(DELTA_W-TIME_W){1'b0}}, clip_ff})) begin
               // Running backwards past or onto the start.
               nt_in = '0;
               nr_in = 1'b0;
            end else begin
               nt_in = (diff_cd[TIME_W-1:0] > dur_ff) ? dur_ff : diff_cd[TIME_W-1:0];
            end
         end
      end
      if (cmd.set_place) begin
         fix_in = 1'b0;
         if (looping_ff) begin
            nt_in = '0;
         end else if (set_t > {{(SET_W-TIME_W){1'b0}}, dur_ff}) begin
            nt_in = dur_ff;
         end else begin
            nt_in = set_t[TIME_W-1:0];
         end
      end
      if (cmd.take_time) begin
         if (!fix_ff) begin
            nt_in = div_rem;
         end else begin
            nt_in = (div_rem == '0) ? '0 : (dur_ff - div_rem);
         end
      end
      if (cmd.pose && !pose_skip) begin
         if (period_ff == '0) begin
            na_in = '0;
            ns_in = 1'b1;
         end else if (acc_below) begin
            na_in = acc_sat;
            ns_in = changed_run;
         end
      end
      if (cmd.take_acc) begin
         na_in = div_rem[ACC_W-1:0];
         ns_in = 1'b1;
      end
   end

   // Committed clip state.
   always_comb begin
      clip_in = clip_ff;
      run_in  = run_ff;
      acc_in  = acc_ff;
      if (cmd.commit) begin
         clip_in = nt_ff;
         run_in  = nr_ff;
         acc_in  = na_ff;
      end
   end

   // Configuration and clip state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         looping_ff <= 1'b0;
         speed_ff   <= SPEED_RESET;
         rate_ff    <= '0;
         dur_ff     <= '0;
         period_ff  <= '0;
         clip_ff    <= '0;
         run_ff     <= 1'b0;
         acc_ff     <= '0;
      end else begin
         clip_ff <= clip_in;
         run_ff  <= run_in;
         acc_ff  <= acc_in;
         if (csr_write) begin
            case (csr_index)
               CSR_ENABLED:  enabled_ff <= csr_wdata[0];
               CSR_LOOPING:  looping_ff <= csr_wdata[0];
               CSR_SPEED:    speed_ff   <= csr_wdata[SPEED_W-1:0];
               CSR_RATE:     rate_ff    <= csr_wdata[RATE_W-1:0];
               CSR_DURATION: dur_ff     <= csr_wdata[TIME_W-1:0];
               CSR_PERIOD:   period_ff  <= csr_wdata[PERIOD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Item, product and result registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_payload.op;
         secs_ff <= req_payload.seconds;
      end
      if (cmd.mul_p) begin
         p_ff <= mul_y;
      end
      if (cmd.mul_hi) begin
         prod_ff <= mul_y[PROD_W-1:0];
      end
      if (cmd.mul_lo) begin
         d_ff <= {1'b0, prod_ff, 4'b0000}
                 + {{(DELTA_W-(PROD_W-20)){1'b0}}, mul_y[PROD_W-1:20]};
      end
      nt_ff  <= nt_in;
      nr_ff  <= nr_in;
      ns_ff  <= ns_in;
      na_ff  <= na_in;
      fix_ff <= fix_in;
      if (cmd.commit) begin
         rsp_ff.clip_ticks  <= nt_ff;
         rsp_ff.playing     <= nr_ff;
         rsp_ff.pose_update <= ns_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/core/apc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playback clock controller
// Sequences one item through the multiplier, the advance logic, the
// remainder unit and the rate limiter, and owns both handshakes.
// ----------------------------------------------------------------------------
module apc_ctrl import apc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  apc_status_type st,
   output apc_cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_MUL_P  = 10'b00_0000_0010,
      S_MUL_HI = 10'b00_0000_0100,
      S_MUL_LO = 10'b00_0000_1000,
      S_ADV    = 10'b00_0001_0000,
      S_SET    = 10'b00_0010_0000,
      S_DIV_T  = 10'b00_0100_0000,
      S_POSE   = 10'b00_1000_0000,
      S_DIV_A  = 10'b01_0000_0000,
      S_FIN    = 10'b10_0000_0000
   } apc_state_type;

   apc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_MUL_P;
         end
         S_MUL_P: begin
            if (st.op_tick && st.adv_ok) state_in = S_MUL_HI;
            else if (st.op_set)          state_in = S_SET;
            else                         state_in = S_FIN;
         end
         S_MUL_HI: state_in = S_MUL_LO;
         S_MUL_LO: state_in = S_ADV;
         S_ADV: begin
            state_in = st.looping ? S_DIV_T : S_POSE;
         end
         S_SET: begin
            state_in = st.set_div ? S_DIV_T : S_FIN;
         end
         S_DIV_T: begin
            if (st.div_done) state_in = st.op_tick ? S_POSE : S_FIN;
         end
         S_POSE: begin
            state_in = st.need_acc_div ? S_DIV_A : S_FIN;
         end
         S_DIV_A: begin
            if (st.div_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.mul_p     = state_ff == S_MUL_P;
      cmd.mul_hi    = state_ff == S_MUL_HI;
      cmd.mul_lo    = state_ff == S_MUL_LO;
      cmd.adv       = state_ff == S_ADV;
      cmd.set_place = state_ff == S_SET;
      cmd.take_time = (state_ff == S_DIV_T) && st.div_done;
      cmd.pose      = state_ff == S_POSE;
      cmd.take_acc  = (state_ff == S_DIV_A) && st.div_done;
      cmd.commit    = (state_ff == S_FIN) && out_free;
   end

   // The result register holds its item until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // The block takes no second item in the cycle after it took one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while a previous item was still at work");

   // The remainder unit only finishes while the controller waits for it.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      st.div_done |-> (state_ff == S_DIV_T || state_ff == S_DIV_A))
      else $error("remainder result arrived outside a division wait");

   // A committed item is offered on the result channel in the next cycle.
   a_commit_offers: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid && state_ff == S_IDLE))
      else $error("committed item not offered on the result channel");

endmodule

// ----- rtl/core/animation_playback_clock_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animation playback clock
// Clip playback timer: tick, play, pause, stop and set_time commands drive
// the clip time, the run flag and a rate-limited pose-update strobe.
// ----------------------------------------------------------------------------
// Play, pause, stop and idle ticks take no division, nor do a clamped set_time
// or a clamped tick; a wrapping set_time, a wrapping tick and a wrapping pose
// accumulator each run the remainder unit, two bits per cycle. One item is at
// work at a time; the next is accepted the cycle after the result is registered.
// Synchronous reset restores all defaults.
module animation_playback_clock_core import apc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  apc_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output apc_rsp_type           rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   apc_cmd_type    cmd;
   apc_status_type st;

   apc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   apc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .st          (st)
   );

endmodule
